// ----- rtl/core/mlaw_pkg.sv -----
// shared types and constants for the mu-law decoder with 2x interpolation
// no dependencies
package mlaw_pkg;

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned POS_W    = 16;
   localparam int unsigned CODE_W   = 8;
   localparam int unsigned ADDR_W   = 3;
   localparam int unsigned DATA_W   = 32;

   // expansion constants
   localparam logic [14:0] MU_BIAS = 15'h0084;

   // input operations
   typedef enum logic {
      OP_DECODE = 1'b0,
      OP_START  = 1'b1
   } op_type;

   // register indexes, taken from paddr[2]
   typedef enum logic {
      REG_START_POSITION = 1'b0,
      REG_STREAM_LENGTH  = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [POS_W-1:0] start_position;
      logic [POS_W-1:0] stream_length;
   } cfg_type;

   // what the control stage hands to the result buffer
   typedef struct packed {
      logic                       load;
      logic                       has_mid;
      logic signed [SAMPLE_W-1:0] mid;
      logic signed [SAMPLE_W-1:0] cur;
   } res_load_type;

endpackage

// ----- rtl/core/mlaw_csr.sv -----
// configuration registers behind the APB-style port
// depends on mlaw_pkg
module mlaw_csr import mlaw_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr_en;

   assign pready = 1'b1;
   assign idx    = reg_index_type'(paddr[2]);
   assign wr_en  = psel & penable & pwrite & pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_START_POSITION: cfg_in.start_position = pwdata[POS_W-1:0];
            REG_STREAM_LENGTH:  cfg_in.stream_length  = pwdata[POS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_START_POSITION: prdata = {{(DATA_W-POS_W){1'b0}}, cfg_ff.start_position};
         REG_STREAM_LENGTH:  prdata = {{(DATA_W-POS_W){1'b0}}, cfg_ff.stream_length};
         default:            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/mlaw_expand.sv -----
// mu-law code to signed 16-bit linear sample
// depends on mlaw_pkg
module mlaw_expand import mlaw_pkg::*; (
   input  logic        [CODE_W-1:0]   code,
   output logic signed [SAMPLE_W-1:0] sample
);

   logic [CODE_W-1:0] u;
   logic [2:0]        ex;
   logic [3:0]        mant;
   logic [14:0]       biased;
   logic [14:0]       mag;

   always_comb begin
      u      = ~code;
      ex     = u[6:4];
      mant   = u[3:0];
      biased = {8'd0, mant, 3'd0} + MU_BIAS;
      // at most 252 << 7, so 15 bits hold it
      mag    = (biased << ex) - MU_BIAS;
      if (u[7]) begin
         sample = -$signed({1'b0, mag});
      end else begin
         sample = $signed({1'b0, mag});
      end
   end

endmodule

// ----- rtl/core/mlaw_resbuf.sv -----
// result buffer: holds the midpoint and the decoded sample of one byte
// depends on mlaw_pkg
module mlaw_resbuf import mlaw_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  res_load_type               res_load,
   output logic                       free,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_sample,
   output logic                       rsp_is_interpolated,
   output logic                       rsp_last
);

   logic                       mid_pend_ff, mid_pend_in;
   logic                       cur_pend_ff, cur_pend_in;
   logic signed [SAMPLE_W-1:0] mid_ff, mid_in;
   logic signed [SAMPLE_W-1:0] cur_ff, cur_in;
   logic                       take;

   assign rsp_valid           = mid_pend_ff | cur_pend_ff;
   assign rsp_pcm_sample      = mid_pend_ff ? mid_ff : cur_ff;
   assign rsp_is_interpolated = mid_pend_ff;
   assign rsp_last            = ~mid_pend_ff;
   assign take                = rsp_valid & rsp_ready;
   // empty, or the final sample leaves in this cycle
   assign free                = ~rsp_valid | (take & ~mid_pend_ff);

   always_comb begin
      mid_pend_in = mid_pend_ff;
      cur_pend_in = cur_pend_ff;
      mid_in      = mid_ff;
      cur_in      = cur_ff;
      if (take) begin
         if (mid_pend_ff) begin
            mid_pend_in = 1'b0;
         end else begin
            cur_pend_in = 1'b0;
         end
      end
      if (res_load.load) begin
         mid_pend_in = res_load.has_mid;
         cur_pend_in = 1'b1;
         mid_in      = res_load.mid;
         cur_in      = res_load.cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_pend_ff <= 1'b0;
         cur_pend_ff <= 1'b0;
      end else begin
         mid_pend_ff <= mid_pend_in;
         cur_pend_ff <= cur_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
      cur_ff <= cur_in;
   end

endmodule

// ----- rtl/core/mulaw_decode_2x_interpolator.sv -----
// mu-law decoder with 2x interpolation, top level
// flow: an input transfer is registered in stage 1, then decoded into the result buffer
//   once the buffer is free; the buffer registers the results for the response port
// throughput: one byte per cycle while rsp_ready stays high and no byte yields a midpoint;
//   a byte with midpoint and sample holds the next until both leave the two-entry result buffer
// reset: synchronous, active high; clears registers, playback state and buffer
module mulaw_decode_2x_interpolator import mlaw_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic        [CODE_W-1:0]   req_mulaw_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_pcm_sample,
   output logic                       rsp_is_interpolated,
   output logic                       rsp_last,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic        [ADDR_W-1:0]   paddr,
   input  logic        [DATA_W-1:0]   pwdata,
   output logic        [DATA_W-1:0]   prdata,
   output logic                       pready
);

   cfg_type      cfg;
   res_load_type res_load;
   logic         buf_free;

   logic                       s1_valid_ff, s1_valid_in;
   op_type                     s1_op_ff;
   logic        [CODE_W-1:0]   s1_byte_ff;
   logic        [POS_W-1:0]    position_ff, position_in;
   logic                       playing_ff, playing_in;
   logic                       have_prev_ff, have_prev_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic signed [SAMPLE_W-1:0] cur;
   logic signed [SAMPLE_W:0]   mid_sum;
   logic                       s1_go;
   logic                       req_xfer;

   mlaw_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mlaw_expand u_expand (
      .code   (s1_byte_ff),
      .sample (cur)
   );

   mlaw_resbuf u_resbuf (
      .clock               (clock),
      .reset               (reset),
      .res_load            (res_load),
      .free                (buf_free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pcm_sample      (rsp_pcm_sample),
      .rsp_is_interpolated (rsp_is_interpolated),
      .rsp_last            (rsp_last)
   );

   assign s1_go     = s1_valid_ff & buf_free;
   assign req_ready = ~s1_valid_ff | buf_free;
   assign req_xfer  = req_valid & req_ready;

   // rounds halves toward plus infinity; sum of two samples plus one fits 17 bits
   assign mid_sum = $signed({prev_ff[SAMPLE_W-1], prev_ff})
                  + $signed({cur[SAMPLE_W-1], cur}) + 17'sd1;

   always_comb begin
      s1_valid_in      = s1_valid_ff;
      position_in      = position_ff;
      playing_in       = playing_ff;
      have_prev_in     = have_prev_ff;
      prev_in          = prev_ff;
      res_load.load    = 1'b0;
      res_load.has_mid = have_prev_ff;
      res_load.mid     = mid_sum[SAMPLE_W:1];
      res_load.cur     = cur;

      if (s1_go) begin
         s1_valid_in = 1'b0;
         unique case (s1_op_ff)
            OP_START: begin
               position_in  = cfg.start_position;
               playing_in   = 1'b1;
               have_prev_in = 1'b0;
            end
            OP_DECODE: begin
               if (playing_ff) begin
                  if (position_ff >= cfg.stream_length) begin
                     playing_in = 1'b0;
                  end else begin
                     position_in   = position_ff + 16'd1;
                     have_prev_in  = 1'b1;
                     prev_in       = cur;
                     res_load.load = 1'b1;
                  end
               end
            end
            default: s1_valid_in = 1'b0;
         endcase
      end
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         position_ff  <= '0;
         playing_ff   <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         position_ff  <= position_in;
         playing_ff   <= playing_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (req_xfer) begin
         s1_op_ff   <= op_type'(req_operation);
         s1_byte_ff <= req_mulaw_byte;
      end
   end

endmodule

// ----- tb/mulaw_decode_2x_interpolator_test.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the mu-law decoder with 2x interpolation: random idling
// on both channels, register phases from extreme to random, samples predicted per byte
// depends on mlaw_pkg and the mulaw_decode_2x_interpolator rtl
module mulaw_decode_2x_interpolator_test;
   import mlaw_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;
   localparam logic [CODE_W-1:0] CORNER_CODES [12] = '{
      8'h00, 8'h80, 8'hFF, 8'h7F, 8'h0F, 8'h8F, 8'hF0, 8'h70, 8'h01, 8'hFE, 8'h7E, 8'h81
   };

   typedef struct {
      logic signed [SAMPLE_W-1:0] pcm;
      logic                       interp;
      logic                       last;
   } pcm_result_type;

   // tracks playback state and the samples still owed by the block
   class pcm_expectation;
      logic [POS_W-1:0]           start_reg;
      logic [POS_W-1:0]           length_reg;
      logic [POS_W-1:0]           position;
      bit                         playing;
      bit                         have_prev;
      logic signed [SAMPLE_W-1:0] prev_sample;
      pcm_result_type             pcm_due_q[$];
      int                         errors;
      int                         checked;
      int                         midpoints;
      int                         starts;
      int                         drops;

      function new();
         start_reg   = '0;
         length_reg  = '0;
         position    = '0;
         playing     = 1'b0;
         have_prev   = 1'b0;
         prev_sample = '0;
         errors      = 0;
         checked     = 0;
         midpoints   = 0;
         starts      = 0;
         drops       = 0;
      endfunction

      function void set_register(reg_index_type idx, logic [POS_W-1:0] value);
         if (idx == REG_START_POSITION)
            start_reg = value;
         else
            length_reg = value;
      endfunction

      function logic signed [SAMPLE_W-1:0] expand_mulaw(logic [CODE_W-1:0] code);
         logic [CODE_W-1:0] inv;
         int                mag;
         inv = ~code;
         mag = (((int'(inv[3:0]) << 3) + int'(MU_BIAS)) << inv[6:4]) - int'(MU_BIAS);
         return inv[7] ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
      endfunction

      // returns 1 when the transfer starts playback or yields samples
      function bit note_input(op_type op, logic [CODE_W-1:0] code);
         logic signed [SAMPLE_W-1:0] cur;
         int                         mid;
         if (op == OP_START) begin
            position  = start_reg;
            playing   = 1'b1;
            have_prev = 1'b0;
            starts++;
            return 1'b1;
         end
         if (!playing || position >= length_reg) begin
            playing = 1'b0;
            drops++;
            return 1'b0;
         end
         cur      = expand_mulaw(code);
         position = position + 1'b1;
         if (have_prev) begin
            // arithmetic shift on the signed sum rounds toward minus infinity
            mid = (int'(prev_sample) + int'(cur) + 1) >>> 1;
            pcm_due_q.push_back('{SAMPLE_W'(mid), 1'b1, 1'b0});
            midpoints++;
         end
         pcm_due_q.push_back('{cur, 1'b0, 1'b1});
         prev_sample = cur;
         have_prev   = 1'b1;
         return 1'b1;
      endfunction

      function void check_result(logic signed [SAMPLE_W-1:0] pcm, logic interp, logic last);
         pcm_result_type want;
         if (pcm_due_q.size() == 0) begin
            $display("%0t: pcm transfer with nothing outstanding: pcm %0d interp %b last %b",
                     $time, pcm, interp, last);
            errors++;
            return;
         end
         want = pcm_due_q.pop_front();
         checked++;
         if (pcm !== want.pcm) begin
            $display("%0t: pcm_sample expected %0d actual %0d", $time, want.pcm, pcm);
            errors++;
         end
         if (interp !== want.interp) begin
            $display("%0t: is_interpolated expected %b actual %b", $time, want.interp, interp);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   op_type                     req_operation = OP_DECODE;
   logic        [CODE_W-1:0]   req_mulaw_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b1;
   logic signed [SAMPLE_W-1:0] rsp_pcm_sample;
   logic                       rsp_is_interpolated;
   logic                       rsp_last;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic        [ADDR_W-1:0]   paddr = '0;
   logic        [DATA_W-1:0]   pwdata = '0;
   logic        [DATA_W-1:0]   prdata;
   logic                       pready;

   pcm_expectation pcm_pred;
   bit             tx_steady = 1'b0;
   bit             rx_steady = 1'b0;
   logic [3:0]     rsp_hold = '0;
   int             quiet_cycles = 0;

   mulaw_decode_2x_interpolator u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_operation       (req_operation),
      .req_mulaw_byte      (req_mulaw_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pcm_sample      (rsp_pcm_sample),
      .rsp_is_interpolated (rsp_is_interpolated),
      .rsp_last            (rsp_last),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result side: check each transfer, then stall for a drawn number of cycles
   always @(posedge clock) begin
      int draw;
      if (reset) begin
         rsp_ready <= 1'b1;
         rsp_hold  <= '0;
      end else if (rsp_valid && rsp_ready) begin
         pcm_pred.check_result(rsp_pcm_sample, rsp_is_interpolated, rsp_last);
         draw = rx_steady ? 0 : $urandom_range(0, 15);
         rsp_hold  <= 4'(draw);
         rsp_ready <= (draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1'b1;
         rsp_ready <= (rsp_hold == 4'd1);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d samples outstanding",
                  $time, WATCHDOG_LIMIT, pcm_pred.pcm_due_q.size());
         $display("mulaw_decode_2x_interpolator_test: FAIL");
         $finish;
      end
   end

   // write a register, then read it back
   task automatic cfg_write(reg_index_type idx, logic [POS_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {16'($urandom_range(0, 65535)), value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      pcm_pred.set_register(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[POS_W-1:0] !== value) begin
         $display("%0t: register %s read expected %0d actual %0d",
                  $time, idx.name(), value, prdata[POS_W-1:0]);
         pcm_pred.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_item(op_type op, logic [CODE_W-1:0] code, output bit counted);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_mulaw_byte <= code;
      do @(posedge clock); while (!req_ready);
      counted = pcm_pred.note_input(op, code);
   endtask

   // drop valid and let every owed sample come out, then wait out SETTLE_CYCLES for dropped bytes
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pcm_pred.pcm_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [POS_W-1:0] first_pos, logic [POS_W-1:0] end_pos,
                            int quota, int start_odds, bit steady);
      int     counted_items;
      int     sent_items;
      bit     counted;
      bit     paused;
      op_type op;
      counted_items = 0;
      sent_items    = 0;
      paused        = 1'b0;
      tx_steady = steady || ($urandom_range(0, 3) == 0);
      rx_steady = steady || ($urandom_range(0, 3) == 0);
      cfg_write(REG_START_POSITION, first_pos);
      cfg_write(REG_STREAM_LENGTH, end_pos);
      send_item(OP_START, 8'($urandom_range(0, 255)), counted);
      while (counted_items < quota && sent_items < 4 * quota) begin
         if (!paused && counted_items >= quota / 2) begin
            // hold the sender until the result side has caught up
            wait_drained();
            paused = 1'b1;
         end
         op = ($urandom_range(1, start_odds) == 1) ? OP_START : OP_DECODE;
         send_item(op, 8'($urandom_range(0, 255)), counted);
         sent_items++;
         if (counted)
            counted_items++;
      end
      wait_drained();
   endtask

   initial begin
      bit               counted;
      logic [POS_W-1:0] base_pos;
      pcm_pred = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // byte before any start is dropped
      send_item(OP_DECODE, 8'h00, counted);
      wait_drained();
      cfg_write(REG_START_POSITION, 16'd0);
      cfg_write(REG_STREAM_LENGTH, 16'd12);
      send_item(OP_START, 8'hFF, counted);
      foreach (CORNER_CODES[i])
         send_item(OP_DECODE, CORNER_CODES[i], counted);
      // end of stream, then a byte while stopped
      send_item(OP_DECODE, 8'h55, counted);
      send_item(OP_DECODE, 8'hAA, counted);
      wait_drained();
      // start already at the length: first byte ends playback
      cfg_write(REG_START_POSITION, 16'd5);
      cfg_write(REG_STREAM_LENGTH, 16'd5);
      send_item(OP_START, 8'h00, counted);
      send_item(OP_DECODE, 8'h33, counted);
      wait_drained();

      run_phase(16'd0, 16'hFFFF, 150, 32, 1'b0);
      run_phase(16'hFFFF, 16'hFFFF, 30, 4, 1'b0);
      run_phase(16'd0, 16'd0, 30, 4, 1'b0);
      run_phase(16'hFFFE, 16'hFFFF, 40, 4, 1'b0);
      base_pos = 16'($urandom_range(0, 65000));
      run_phase(base_pos, base_pos + 16'($urandom_range(10, 60)), 120, 40, 1'b0);
      run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)), 80, 16, 1'b0);
      run_phase(16'd100, 16'd130, 120, 50, 1'b0);
      run_phase(16'd0, 16'hFFFF, 120, 32, 1'b1);

      repeat (8) @(posedge clock);
      $display("checked %0d pcm samples, %0d of them midpoints, across %0d playback starts",
               pcm_pred.checked, pcm_pred.midpoints, pcm_pred.starts);
      $display("%0d bytes dropped while stopped or past the stream end, %0d errors",
               pcm_pred.drops, pcm_pred.errors);
      if (pcm_pred.errors == 0 && pcm_pred.pcm_due_q.size() == 0)
         $display("mulaw_decode_2x_interpolator_test: PASS");
      else
         $display("mulaw_decode_2x_interpolator_test: FAIL");
      $finish;
   end

endmodule
